>>> hw/rtl/cdg_pkg.sv
package cdg_pkg;

  // Defaults for the top-level parameters
  localparam int PIXEL_BITS_DEF = 16;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // Fixed field widths
  localparam int GRAD_W    = 17;
  localparam int POS_W     = 10;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_W-1:0]     WIDTH_RESET      = CFG_W'(640);
  localparam logic [CFG_W-1:0]     HEIGHT_RESET     = CFG_W'(480);

  // Classification of one pixel, carried from front to back
  typedef struct packed {
    logic             has_up;    // row above exists
    logic             up_far;    // two rows above exist
    logic             last_row;  // pixel sits in the last row
    logic             c_pos;     // column above zero
    logic             c_gt1;     // column above one
    logic             c_last;    // last column of the row
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } cdg_ctrl_t;

  // Queue status
  typedef struct packed {
    logic full;
    logic valid;
  } cdg_q_stat_t;

endpackage

>>> hw/rtl/cdg_if.sv
interface cdg_pixel_if #(parameter int PIXEL_BITS = cdg_pkg::PIXEL_BITS_DEF);
  logic                         valid;
  logic                         ready;
  logic signed [PIXEL_BITS-1:0] pixel_value;
  logic                         pixel_valid;

  modport source(output valid, pixel_value, pixel_valid, input ready);
  modport sink(input valid, pixel_value, pixel_valid, output ready);
endinterface

interface cdg_grad_if;
  import cdg_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [GRAD_W-1:0] grad_x;
  logic signed [GRAD_W-1:0] grad_y;
  logic                     grad_x_valid;
  logic                     grad_y_valid;
  logic [POS_W-1:0]         out_row;
  logic [POS_W-1:0]         out_col;
  logic                     run_last;

  modport source(output valid, grad_x, grad_y, grad_x_valid, grad_y_valid, out_row, out_col,
                 run_last, input ready);
  modport sink(input valid, grad_x, grad_y, grad_x_valid, grad_y_valid, out_row, out_col,
               run_last, output ready);
endinterface

interface cdg_cfg_if;
  import cdg_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> hw/rtl/cdg_front.sv
module cdg_front #(
  parameter int MAX_WIDTH  = cdg_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cdg_pkg::MAX_HEIGHT_DEF,
  parameter int PIXEL_BITS = cdg_pkg::PIXEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  cdg_pixel_if.sink                     pixel_in,
  cdg_cfg_if.sink                       cfg,
  input  logic                          q_full,
  output logic                          push,
  output cdg_pkg::cdg_ctrl_t            ctrl,
  output logic [$clog2(MAX_WIDTH)-1:0]  c_addr,
  output logic [$clog2(MAX_WIDTH)-1:0]  n_addr,
  output logic [PIXEL_BITS:0]           pix
);
  import cdg_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int HB = $clog2(MAX_HEIGHT + 1);

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [CW-1:0]    col;
  logic [RW-1:0]    row;

  logic [WB-1:0] w;
  logic [HB-1:0] h;
  logic          col_wrap;
  logic [HB-1:0] row_step;
  logic [CW-1:0] c;
  logic [RW-1:0] r;
  logic [WB-1:0] c_inc;
  logic [HB-1:0] r_inc;

  // Take config writes at any time
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == REG_IMAGE_WIDTH) begin
        image_width <= cfg.data;
      end
      if (cfg.index == REG_IMAGE_HEIGHT) begin
        image_height <= cfg.data;
      end
    end
  end

  // Clamp the sizes into 1..max
  always_comb begin
    if (image_width == '0) begin
      w = WB'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w = WB'(MAX_WIDTH);
    end else begin
      w = WB'(image_width);
    end
    if (image_height == '0) begin
      h = HB'(1);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      h = HB'(MAX_HEIGHT);
    end else begin
      h = HB'(image_height);
    end
  end

  // Wrap stale counters against the current size, then place the pixel
  always_comb begin
    col_wrap = WB'(col) >= w;
    c        = col_wrap ? '0 : col;
    row_step = col_wrap ? HB'(row) + HB'(1) : HB'(row);
    r        = (row_step >= h) ? '0 : RW'(row_step);
    c_inc    = WB'(c) + WB'(1);
    r_inc    = HB'(r) + HB'(1);
  end

  assign pixel_in.ready = !q_full;
  assign push           = pixel_in.valid && !q_full;

  // Classify the pixel for the back end
  always_comb begin
    ctrl.has_up   = r != '0;
    ctrl.up_far   = (r != '0) && (r != RW'(1));
    ctrl.last_row = HB'(r) == h - HB'(1);
    ctrl.c_pos    = c != '0;
    ctrl.c_gt1    = (c != '0) && (c != CW'(1));
    ctrl.c_last   = WB'(c) == w - WB'(1);
    ctrl.row      = POS_W'(r);
    ctrl.col      = POS_W'(c);
    c_addr        = c;
    n_addr        = (c_inc < w) ? CW'(c_inc) : c;
    pix           = {pixel_in.pixel_valid, PIXEL_BITS'(pixel_in.pixel_value)};
  end

  // Advance the raster position on each request
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (push) begin
      if (c_inc >= w) begin
        col <= '0;
        row <= (r_inc >= h) ? '0 : RW'(r_inc);
      end else begin
        col <= CW'(c_inc);
        row <= r;
      end
    end
  end

endmodule

>>> hw/rtl/cdg_queue.sv
module cdg_queue #(
  parameter int DATA_W = 1,
  parameter int DEPTH  = cdg_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [DATA_W-1:0]   wdata,
  input  logic                pop,
  output logic [DATA_W-1:0]   rdata,
  output cdg_pkg::cdg_q_stat_t stat
);
  import cdg_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [NW-1:0]     count;

  assign rdata      = slots[rd_ptr];
  assign stat.full  = count == NW'(DEPTH);
  assign stat.valid = count != '0;

  // Store the incoming request
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // Move pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

endmodule

>>> hw/rtl/cdg_back.sv
module cdg_back #(
  parameter int MAX_WIDTH  = cdg_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = cdg_pkg::PIXEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  cdg_pkg::cdg_ctrl_t            q_ctrl,
  input  logic [$clog2(MAX_WIDTH)-1:0]  q_c,
  input  logic [$clog2(MAX_WIDTH)-1:0]  q_cn,
  input  logic [PIXEL_BITS:0]           q_pix,
  cdg_grad_if.source                    grad_out
);
  import cdg_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int EW = PIXEL_BITS + 1;
  localparam int DW = (EW > GRAD_W) ? EW : GRAD_W;

  // Line stores: value with its valid bit on top
  logic [EW-1:0] prev_mem [MAX_WIDTH];
  logic [EW-1:0] old_mem  [MAX_WIDTH];

  logic [EW-1:0] raw_pc;
  logic [EW-1:0] raw_pn;
  logic [EW-1:0] raw_oc;
  logic          fwd_c;
  logic          fwd_n;
  logic [EW-1:0] fwd_cur;
  logic [EW-1:0] fwd_old;

  logic          s1_valid;
  cdg_ctrl_t     s1_ctrl;
  logic [AW-1:0] s1_c;
  logic [EW-1:0] s1_cur;
  logic [2:0]    pend;

  logic [EW-1:0] left_px;
  logic [EW-1:0] rec0;
  logic [EW-1:0] rec1;

  logic [EW-1:0]    pc_eff;
  logic [EW-1:0]    pn_eff;
  logic [EW-1:0]    oc_eff;
  logic [2:0]       pend_rest;
  logic             out_load;
  logic             s1_done;
  logic [EW-1:0]    lx;
  logic [EW-1:0]    rx;
  logic [EW-1:0]    uy;
  logic [EW-1:0]    dy;
  logic [POS_W-1:0] sel_row;
  logic [POS_W-1:0] sel_col;
  logic             vx;
  logic             vy;
  logic signed [DW-1:0] gx_full;
  logic signed [DW-1:0] gy_full;

  // Bypass a write that lands on the same edge as the read
  assign pc_eff = fwd_c ? fwd_cur : raw_pc;
  assign oc_eff = fwd_c ? fwd_old : raw_oc;
  assign pn_eff = fwd_n ? fwd_cur : raw_pn;

  // Results still owed: bit 0 row above, bit 1 left neighbour, bit 2 row flush
  assign pend_rest = pend & (pend - 3'd1);
  assign out_load  = s1_valid && (pend != '0) && (!grad_out.valid || grad_out.ready);
  assign s1_done   = s1_valid && ((pend == '0) || (out_load && (pend_rest == '0)));
  assign q_pop     = q_valid && (!s1_valid || s1_done);

  // Previous-row store: write the retiring pixel, read at column and column plus one
  always_ff @(posedge clk) begin
    if (s1_done) begin
      prev_mem[s1_c] <= s1_cur;
    end
    if (q_pop) begin
      raw_pc <= prev_mem[q_c];
      raw_pn <= prev_mem[q_cn];
    end
  end

  // Older-row store: takes what the previous-row store held
  always_ff @(posedge clk) begin
    if (s1_done) begin
      old_mem[s1_c] <= pc_eff;
    end
    if (q_pop) begin
      raw_oc <= old_mem[q_c];
    end
  end

  // Capture bypass data and the item entering the result stage
  always_ff @(posedge clk) begin
    if (q_pop) begin
      fwd_c   <= s1_done && (q_c == s1_c);
      fwd_n   <= s1_done && (q_cn == s1_c);
      fwd_cur <= s1_cur;
      fwd_old <= pc_eff;
      s1_ctrl <= q_ctrl;
      s1_c    <= q_c;
      s1_cur  <= q_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      pend     <= '0;
    end else if (q_pop) begin
      s1_valid <= 1'b1;
      pend     <= {q_ctrl.last_row && q_ctrl.c_last,
                   q_ctrl.last_row && q_ctrl.c_pos,
                   q_ctrl.has_up};
    end else begin
      if (s1_done) begin
        s1_valid <= 1'b0;
      end
      if (out_load) begin
        pend <= pend_rest;
      end
    end
  end

  // Hold the neighbours of the next pixel in the row
  always_ff @(posedge clk) begin
    if (s1_done) begin
      left_px <= pc_eff;
      rec0    <= s1_cur;
      rec1    <= rec0;
    end
  end

  // Pick the four source pixels of the result owed first
  always_comb begin
    if (pend[0]) begin
      lx      = s1_ctrl.c_pos ? left_px : pc_eff;
      rx      = pn_eff;
      uy      = s1_ctrl.up_far ? oc_eff : pc_eff;
      dy      = s1_cur;
      sel_row = s1_ctrl.row - POS_W'(1);
      sel_col = s1_ctrl.col;
    end else if (pend[1]) begin
      lx      = s1_ctrl.c_gt1 ? rec1 : rec0;
      rx      = s1_cur;
      uy      = s1_ctrl.has_up ? left_px : rec0;
      dy      = rec0;
      sel_row = s1_ctrl.row;
      sel_col = s1_ctrl.col - POS_W'(1);
    end else begin
      lx      = s1_ctrl.c_pos ? rec0 : s1_cur;
      rx      = s1_cur;
      uy      = s1_ctrl.has_up ? pc_eff : s1_cur;
      dy      = s1_cur;
      sel_row = s1_ctrl.row;
      sel_col = s1_ctrl.col;
    end
  end

  // Differences, next minus previous
  always_comb begin
    vx      = lx[EW-1] && rx[EW-1];
    vy      = uy[EW-1] && dy[EW-1];
    gx_full = DW'($signed(rx[EW-2:0])) - DW'($signed(lx[EW-2:0]));
    gy_full = DW'($signed(dy[EW-2:0])) - DW'($signed(uy[EW-2:0]));
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      grad_out.valid <= 1'b0;
    end else if (out_load) begin
      grad_out.valid <= 1'b1;
    end else if (grad_out.ready) begin
      grad_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      grad_out.grad_x       <= vx ? gx_full[GRAD_W-1:0] : '0;
      grad_out.grad_y       <= vy ? gy_full[GRAD_W-1:0] : '0;
      grad_out.grad_x_valid <= vx;
      grad_out.grad_y_valid <= vy;
      grad_out.out_row      <= sel_row;
      grad_out.out_col      <= sel_col;
      grad_out.run_last     <= pend_rest == '0;
    end
  end

endmodule

>>> hw/rtl/central_difference_gradient.sv
// Channel   Dir  Fields                                          Accepted when
// pixel_in  in   pixel_value, pixel_valid                        valid && ready
// grad_out  out  grad_x, grad_y, grad_x_valid, grad_y_valid,     valid && ready
//                out_row, out_col, run_last
// cfg       in   index (0 image_width, 1 image_height), data     valid && ready (ready tied high)
//
// One pixel per cycle on every row but the last while grad_out is not stalled; the single
// result stage hands out one result per cycle, so a last-row pixel owes up to two results
// and its last column up to three. A request's first result is registered on grad_out
// after it has passed through the queue and the result stage.
// A four-entry queue lets the raster counters keep taking pixels while results stall.
// Synchronous reset clears counters, queue and result stage and sets the sizes to 640 by 480;
// the line stores are not cleared and hold whatever they held until written.
module central_difference_gradient #(
  parameter int MAX_WIDTH  = cdg_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cdg_pkg::MAX_HEIGHT_DEF,
  parameter int PIXEL_BITS = cdg_pkg::PIXEL_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  cdg_pixel_if.sink  pixel_in,
  cdg_cfg_if.sink    cfg,
  cdg_grad_if.source grad_out
);
  import cdg_pkg::*;

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int EW  = PIXEL_BITS + 1;
  localparam int QDW = $bits(cdg_ctrl_t) + 2 * AW + EW;

  logic          f_push;
  cdg_ctrl_t     f_ctrl;
  logic [AW-1:0] f_c;
  logic [AW-1:0] f_cn;
  logic [EW-1:0] f_pix;

  logic [QDW-1:0] q_wdata;
  logic [QDW-1:0] q_rdata;
  cdg_q_stat_t    q_stat;
  logic           q_pop;
  cdg_ctrl_t      q_ctrl;
  logic [AW-1:0]  q_c;
  logic [AW-1:0]  q_cn;
  logic [EW-1:0]  q_pix;

  // Raster position and classification
  cdg_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .pixel_in(pixel_in),
    .cfg     (cfg),
    .q_full  (q_stat.full),
    .push    (f_push),
    .ctrl    (f_ctrl),
    .c_addr  (f_c),
    .n_addr  (f_cn),
    .pix     (f_pix)
  );

  // Queue between front and back
  assign q_wdata                  = {f_ctrl, f_c, f_cn, f_pix};
  assign {q_ctrl, q_c, q_cn, q_pix} = q_rdata;

  cdg_queue #(
    .DATA_W(QDW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (f_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .stat (q_stat)
  );

  // Line stores and result stage
  cdg_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_stat.valid),
    .q_pop   (q_pop),
    .q_ctrl  (q_ctrl),
    .q_c     (q_c),
    .q_cn    (q_cn),
    .q_pix   (q_pix),
    .grad_out(grad_out)
  );

  // A full queue that is not drained keeps the input stalled
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (q_stat.full && !q_pop) |=> !pixel_in.ready)
    else $error("input ready while queue full");

  // Back-to-back pixels inside a row step the column by one when no config write comes between
  a_col_step: assert property (@(posedge clk) disable iff (rst)
    (f_push && !f_ctrl.c_last && !(cfg.valid && cfg.ready)) ##1 f_push
      |-> f_ctrl.col == POS_W'($past(f_ctrl.col) + POS_W'(1)))
    else $error("column did not advance");

  // A result that is not the last of its pixel is followed at once by the next
  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    (grad_out.valid && grad_out.ready && !grad_out.run_last) |=> grad_out.valid)
    else $error("gap inside a run of results");

endmodule
